FILE: rtl/core/ttcd_pkg.sv
`timescale 1ns / 1ps

package ttcd_pkg;

    localparam int SYMBOL_LEN = 256;
    localparam int TAB_BITS   = 10;
    localparam int TAB_SIZE   = 1 << TAB_BITS;

    localparam int SAMPLE_W = 16;
    localparam int CORR_W   = 40;
    localparam int ENERGY_W = 42;
    localparam int PHASE_W  = 16;
    localparam int WAIT_W   = 11;
    localparam int WSYM_W   = 10;
    localparam int THR_W    = 16;

    localparam int K_W    = THR_W + $clog2(SYMBOL_LEN + 1);
    localparam int EH_W   = ENERGY_W / 2;
    localparam int EL_W   = ENERGY_W - EH_W;
    localparam int RHS_W  = K_W + ENERGY_W;
    localparam int MAG_H  = CORR_W / 2;
    localparam int MAG_L  = CORR_W - MAG_H;
    localparam int SQ_W   = 2 * CORR_W;
    localparam int TONE_W = SQ_W + 2;
    localparam int LHS_W  = TONE_W + 16;

    localparam logic [1:0] CFG_TONE0_STEP = 2'd0;
    localparam logic [1:0] CFG_TONE1_STEP = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD  = 2'd2;
    localparam logic [1:0] CFG_WAIT_SYMS  = 2'd3;

    localparam logic [THR_W-1:0]  THR_RESET  = 16'd32768;
    localparam logic [WSYM_W-1:0] WSYM_RESET = 10'd32;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic [63:0] TAYLOR_DIV [10] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
        64'd132, 64'd182, 64'd240, 64'd306, 64'd380
    };

    typedef logic signed [SAMPLE_W-1:0] t_cos_tab [TAB_SIZE];

    function automatic logic signed [SAMPLE_W-1:0] quarter_cos(input int q);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        x    = (64'd2 * PI_Q30 * 64'(q) + 64'(TAB_SIZE / 2)) >> TAB_BITS;
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        sum  = longint'(term);
        for (int k = 1; k <= 10; k++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k-1];
            if ((k & 1) != 0) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        return SAMPLE_W'((64'd32767 * 64'(sum) + (64'd1 << 29)) >> 30);
    endfunction

    function automatic t_cos_tab build_cos_tab();
        t_cos_tab tab;
        int       h;
        int       q;
        h = TAB_SIZE / 2;
        q = TAB_SIZE / 4;
        for (int k = 0; k < TAB_SIZE; k++) begin
            if (k <= q) begin
                tab[k] = quarter_cos(k);
            end else if (k <= h) begin
                tab[k] = -quarter_cos(h - k);
            end else if (k <= h + q) begin
                tab[k] = -quarter_cos(k - h);
            end else begin
                tab[k] = quarter_cos(TAB_SIZE - k);
            end
        end
        return tab;
    endfunction

    localparam t_cos_tab COS_TAB = build_cos_tab();

endpackage

FILE: rtl/core/two_tone_correlation_detector.sv
`timescale 1ns / 1ps
// after the tlast beat is accepted, its result passes stages a to i and the output register
// throughput: one sample beat per cycle, set by the multiply-accumulate pipeline
// the decision pipeline squares and adds the sums in stages e to i, one symbol per cycle
// a result beat not taken parks in a skid register; input stalls only while that is full
// synchronous active-low reset: sums and phases clear, registers and wait count take reset values

module two_tone_correlation_detector
    import ttcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // sample_re, sample_im
    input  logic        i_s_tlast,   // symbol_end
    input  logic        i_s_tuser,   // expect_tone
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // advance, tone_present, timeout_error, zero fill
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic en;
    logic s_accept;

    logic [PHASE_W-1:0] r_step0, r_step1;
    logic [THR_W-1:0]   r_thr;
    logic [WSYM_W-1:0]  r_wsym;
    logic [PHASE_W-1:0] r_phase0, r_phase1;

    // stage a
    logic                       r_a_valid, r_a_last, r_a_expect;
    logic signed [SAMPLE_W-1:0] r_a_re, r_a_im;
    logic [TAB_BITS-1:0]        r_a_idx0, r_a_idx1;
    logic [TAB_BITS-1:0]        sin_idx0, sin_idx1;

    // stage b
    logic                       r_b_valid, r_b_last, r_b_expect;
    logic signed [SAMPLE_W-1:0] r_b_re, r_b_im;
    logic signed [SAMPLE_W-1:0] r_b_cos0, r_b_sin0, r_b_cos1, r_b_sin1;

    // stage c
    logic                 r_c_valid, r_c_last, r_c_expect;
    logic signed [31:0]   r_c_rc0, r_c_is0, r_c_ic0, r_c_rs0;
    logic signed [31:0]   r_c_rc1, r_c_is1, r_c_ic1, r_c_rs1;
    logic [30:0]          r_c_re2, r_c_im2;
    logic signed [31:0]   sq_re, sq_im;

    // accumulators
    logic signed [CORR_W-1:0] r_acc0_re, r_acc0_im, r_acc1_re, r_acc1_im;
    logic [ENERGY_W-1:0]      r_energy;
    logic signed [CORR_W-1:0] n_acc0_re, n_acc0_im, n_acc1_re, n_acc1_im;
    logic [ENERGY_W-1:0]      n_energy;
    logic [31:0]              e_term;
    logic [ENERGY_W:0]        e_sum;

    // stage d: symbol snapshot
    logic                     r_d_valid, r_d_expect;
    logic signed [CORR_W-1:0] r_d_corr [4];
    logic [ENERGY_W-1:0]      r_d_energy;
    logic [THR_W-1:0]         r_d_thr;

    // stage e
    logic                r_e_valid, r_e_expect, r_e_nz;
    logic [CORR_W-1:0]   r_e_mag [4];
    logic [ENERGY_W-1:0] r_e_energy;
    logic [K_W-1:0]      r_e_k;

    // stage f
    logic                  r_f_valid, r_f_expect, r_f_nz;
    logic [2*MAG_H-1:0]    r_f_hh [4];
    logic [MAG_H+MAG_L-1:0] r_f_hl [4];
    logic [2*MAG_L-1:0]    r_f_ll [4];
    logic [K_W+EH_W-1:0]   r_f_kh;
    logic [K_W+EL_W-1:0]   r_f_kl;

    // stage g
    logic             r_g_valid, r_g_expect, r_g_nz;
    logic [SQ_W-1:0]  r_g_sq [4];
    logic [RHS_W-1:0] r_g_rhs;

    // stage h
    logic               r_h_valid, r_h_expect, r_h_nz;
    logic [SQ_W:0]      r_h_pair0, r_h_pair1;
    logic [RHS_W-1:0]   r_h_rhs;

    // stage i
    logic               r_i_valid, r_i_expect, r_i_nz;
    logic [TONE_W-1:0]  r_i_tone;
    logic [RHS_W-1:0]   r_i_rhs;

    // decision
    logic signed [WAIT_W-1:0] r_wait_cnt, n_wait_cnt, wait_dec;
    logic                     res_valid, res_present, res_met, res_timeout;
    logic [LHS_W-1:0]         lhs;

    // output side
    logic       r_out_valid, r_skid_valid;
    logic [2:0] r_out, r_skid;

    function automatic logic signed [CORR_W-1:0] sat_add(
        input logic signed [CORR_W-1:0] acc,
        input logic signed [32:0]       prod
    );
        logic signed [32:0]       rnd;
        logic signed [CORR_W:0]   s;
        rnd = (prod + 33'sd16384) >>> 15;
        s   = {acc[CORR_W-1], acc} + (CORR_W+1)'(rnd);
        if (s[CORR_W] != s[CORR_W-1]) begin
            return s[CORR_W] ? {1'b1, {(CORR_W-1){1'b0}}} : {1'b0, {(CORR_W-1){1'b1}}};
        end
        return s[CORR_W-1:0];
    endfunction

    function automatic logic [CORR_W-1:0] magnitude(input logic signed [CORR_W-1:0] v);
        return v[CORR_W-1] ? (~v + 1'b1) : v;
    endfunction

    assign en          = !r_skid_valid;
    assign o_s_tready  = en;
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    // configuration registers and phase accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step0  <= '0;
            r_step1  <= '0;
            r_thr    <= THR_RESET;
            r_wsym   <= WSYM_RESET;
            r_phase0 <= '0;
            r_phase1 <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_TONE0_STEP: r_step0 <= i_cfg_data;
                    CFG_TONE1_STEP: r_step1 <= i_cfg_data;
                    CFG_THRESHOLD:  r_thr   <= i_cfg_data;
                    CFG_WAIT_SYMS:  r_wsym  <= i_cfg_data[WSYM_W-1:0];
                    default: ;
                endcase
            end
            if (s_accept) begin
                r_phase0 <= i_s_tlast ? '0 : r_phase0 + r_step0;
                r_phase1 <= i_s_tlast ? '0 : r_phase1 + r_step1;
            end
        end
    end

    assign sin_idx0 = r_a_idx0 - TAB_BITS'(TAB_SIZE / 4);
    assign sin_idx1 = r_a_idx1 - TAB_BITS'(TAB_SIZE / 4);

    assign sq_re  = r_b_re * r_b_re;
    assign sq_im  = r_b_im * r_b_im;

    assign e_term = {1'b0, r_c_re2} + {1'b0, r_c_im2};
    assign e_sum  = {1'b0, r_energy} + (ENERGY_W+1)'(e_term);

    always_comb begin
        n_acc0_re = sat_add(r_acc0_re, 33'(r_c_rc0) + 33'(r_c_is0));
        n_acc0_im = sat_add(r_acc0_im, 33'(r_c_ic0) - 33'(r_c_rs0));
        n_acc1_re = sat_add(r_acc1_re, 33'(r_c_rc1) + 33'(r_c_is1));
        n_acc1_im = sat_add(r_acc1_im, 33'(r_c_ic1) - 33'(r_c_rs1));
        n_energy  = e_sum[ENERGY_W] ? '1 : e_sum[ENERGY_W-1:0];
    end

    // valid bits, accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
            r_g_valid <= 1'b0;
            r_h_valid <= 1'b0;
            r_i_valid <= 1'b0;
            r_acc0_re <= '0;
            r_acc0_im <= '0;
            r_acc1_re <= '0;
            r_acc1_im <= '0;
            r_energy  <= '0;
        end else if (en) begin
            r_a_valid <= i_s_tvalid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid && r_c_last;
            r_e_valid <= r_d_valid;
            r_f_valid <= r_e_valid;
            r_g_valid <= r_f_valid;
            r_h_valid <= r_g_valid;
            r_i_valid <= r_h_valid;
            if (r_c_valid) begin
                if (r_c_last) begin
                    r_acc0_re <= '0;
                    r_acc0_im <= '0;
                    r_acc1_re <= '0;
                    r_acc1_im <= '0;
                    r_energy  <= '0;
                end else begin
                    r_acc0_re <= n_acc0_re;
                    r_acc0_im <= n_acc0_im;
                    r_acc1_re <= n_acc1_re;
                    r_acc1_im <= n_acc1_im;
                    r_energy  <= n_energy;
                end
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_re     <= i_s_tdata[15:0];
            r_a_im     <= i_s_tdata[31:16];
            r_a_last   <= i_s_tlast;
            r_a_expect <= i_s_tuser;
            r_a_idx0   <= r_phase0[PHASE_W-1 -: TAB_BITS];
            r_a_idx1   <= r_phase1[PHASE_W-1 -: TAB_BITS];

            r_b_re     <= r_a_re;
            r_b_im     <= r_a_im;
            r_b_last   <= r_a_last;
            r_b_expect <= r_a_expect;
            r_b_cos0   <= COS_TAB[r_a_idx0];
            r_b_sin0   <= COS_TAB[sin_idx0];
            r_b_cos1   <= COS_TAB[r_a_idx1];
            r_b_sin1   <= COS_TAB[sin_idx1];

            r_c_last   <= r_b_last;
            r_c_expect <= r_b_expect;
            r_c_rc0    <= r_b_re * r_b_cos0;
            r_c_is0    <= r_b_im * r_b_sin0;
            r_c_ic0    <= r_b_im * r_b_cos0;
            r_c_rs0    <= r_b_re * r_b_sin0;
            r_c_rc1    <= r_b_re * r_b_cos1;
            r_c_is1    <= r_b_im * r_b_sin1;
            r_c_ic1    <= r_b_im * r_b_cos1;
            r_c_rs1    <= r_b_re * r_b_sin1;
            r_c_re2    <= sq_re[30:0];
            r_c_im2    <= sq_im[30:0];

            r_d_expect  <= r_c_expect;
            r_d_corr[0] <= n_acc0_re;
            r_d_corr[1] <= n_acc0_im;
            r_d_corr[2] <= n_acc1_re;
            r_d_corr[3] <= n_acc1_im;
            r_d_energy  <= n_energy;
            r_d_thr     <= r_thr;

            r_e_expect <= r_d_expect;
            r_e_nz     <= r_d_energy != '0;
            r_e_energy <= r_d_energy;
            r_e_k      <= K_W'(r_d_thr) * K_W'(SYMBOL_LEN);
            for (int j = 0; j < 4; j++) begin
                r_e_mag[j] <= magnitude(r_d_corr[j]);
            end

            r_f_expect <= r_e_expect;
            r_f_nz     <= r_e_nz;
            r_f_kh     <= (K_W+EH_W)'(r_e_k) * (K_W+EH_W)'(r_e_energy[ENERGY_W-1:EL_W]);
            r_f_kl     <= (K_W+EL_W)'(r_e_k) * (K_W+EL_W)'(r_e_energy[EL_W-1:0]);
            for (int j = 0; j < 4; j++) begin
                r_f_hh[j] <= (2*MAG_H)'(r_e_mag[j][CORR_W-1:MAG_L])
                           * (2*MAG_H)'(r_e_mag[j][CORR_W-1:MAG_L]);
                r_f_hl[j] <= (MAG_H+MAG_L)'(r_e_mag[j][CORR_W-1:MAG_L])
                           * (MAG_H+MAG_L)'(r_e_mag[j][MAG_L-1:0]);
                r_f_ll[j] <= (2*MAG_L)'(r_e_mag[j][MAG_L-1:0])
                           * (2*MAG_L)'(r_e_mag[j][MAG_L-1:0]);
            end

            r_g_expect <= r_f_expect;
            r_g_nz     <= r_f_nz;
            r_g_rhs    <= (RHS_W'(r_f_kh) << EL_W) + RHS_W'(r_f_kl);
            for (int j = 0; j < 4; j++) begin
                r_g_sq[j] <= (SQ_W'(r_f_hh[j]) << (2*MAG_L))
                           + (SQ_W'(r_f_hl[j]) << (MAG_L+1))
                           + SQ_W'(r_f_ll[j]);
            end

            r_h_expect <= r_g_expect;
            r_h_nz     <= r_g_nz;
            r_h_rhs    <= r_g_rhs;
            r_h_pair0  <= (SQ_W+1)'(r_g_sq[0]) + (SQ_W+1)'(r_g_sq[1]);
            r_h_pair1  <= (SQ_W+1)'(r_g_sq[2]) + (SQ_W+1)'(r_g_sq[3]);

            r_i_expect <= r_h_expect;
            r_i_nz     <= r_h_nz;
            r_i_rhs    <= r_h_rhs;
            r_i_tone   <= TONE_W'(r_h_pair0) + TONE_W'(r_h_pair1);
        end
    end

    // decision
    assign lhs         = {r_i_tone, 16'b0};
    assign res_valid   = en && r_i_valid;
    assign res_present = r_i_nz && (lhs > LHS_W'(r_i_rhs));
    assign res_met     = r_i_expect ? res_present : !res_present;
    assign wait_dec    = (r_wait_cnt > -11'sd1) ? r_wait_cnt - 11'sd1 : r_wait_cnt;
    assign n_wait_cnt  = res_met ? WAIT_W'(r_wsym) : wait_dec;
    assign res_timeout = !res_met && n_wait_cnt[WAIT_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_cnt   <= WAIT_W'(WSYM_RESET);
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (res_valid) begin
                r_wait_cnt <= n_wait_cnt;
            end
            if (r_skid_valid) begin
                if (i_m_tready) begin
                    r_out        <= r_skid;
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (res_valid) begin
                if (!r_out_valid || i_m_tready) begin
                    r_out       <= {res_timeout, res_present, res_met};
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid       <= {res_timeout, res_present, res_met};
                    r_skid_valid <= 1'b1;
                end
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0, r_out};

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid beat held without output beat");

    a_phase_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_s_tlast) |=> (r_phase0 == '0 && r_phase1 == '0))
        else $error("phases not cleared after symbol end");

    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_c_valid && r_c_last) |=> (r_energy == '0 && r_acc0_re == '0
            && r_acc1_im == '0))
        else $error("sums not cleared after symbol end");

    a_wait_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && !res_met) |=> (r_wait_cnt == -11'sd1
            || r_wait_cnt == $past(r_wait_cnt) - 11'sd1))
        else $error("wait count wrong after miss");

    a_adv_no_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out[0] && r_out[2]))
        else $error("timeout flagged on advance");

endmodule
